FILE: design/krst_pkg.sv
// ----------------------------------------------------------------------------
// krst_pkg: shared types for the keyed resume slot table
// Operation codes, controller states and the input/result word layouts.
// ----------------------------------------------------------------------------
package krst_pkg;

  localparam int TASK_KEY_W = 16;
  localparam int DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_STAGE  = 2'd0,
    OP_DROP   = 2'd1,
    OP_TAKE   = 2'd2,
    OP_RESUME = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t                   kind;
    logic [TASK_KEY_W-1:0] task_key;
    logic [DATA_W-1:0]     resume_address;
    logic [DATA_W-1:0]     stack_value;
    logic [DATA_W-1:0]     return_value;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic              table_full;
    logic [DATA_W-1:0] out_return;
    logic [DATA_W-1:0] out_address;
    logic [DATA_W-1:0] out_stack;
  } out_word_t;

endpackage

FILE: design/keyed_resume_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_resume_slot_table
// Slot table of parked-task resume records, searched one slot per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel, one word per operation (stage, drop, take,
//           resume lookup) with key and the three values to store.
//   out_* : valid/ready channel, exactly one result word per input word.
//   in_ready is high only while the controller is idle; one operation is
//   in flight at a time.
// Scan:
//   A nonzero key scans the slots in index order through the key memory's
//   single registered read port, one slot compare per cycle. The scan
//   stops at the first hit (a drop walks every slot); a zero key skips
//   the scan and goes straight to the result.
// Reset:
//   rst_n (synchronous) clears the per-slot valid bits, so every slot is
//   free at once; the record memories are not cleared.
// Stall:
//   The result sits in an output register. A new word can be taken while
//   it waits; the next result is held until out_ready drains the register.
// ----------------------------------------------------------------------------
module keyed_resume_slot_table #(
  parameter int SLOT_COUNT = 16,
  parameter int KEY_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  krst_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output krst_pkg::out_word_t out_data
);
  import krst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // record stores
  logic [KEY_BITS-1:0] key_mem [SLOT_COUNT];
  logic [DATA_W-1:0]   addr_mem [SLOT_COUNT];
  logic [DATA_W-1:0]   stk_mem [SLOT_COUNT];
  logic [DATA_W-1:0]   ret_mem [SLOT_COUNT];

  // control state
  state_t              st_r, st_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]    issue_idx_r, issue_idx_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // latched operation
  op_t                 op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [DATA_W-1:0]   addr_r, stk_r, ret_r;

  // result flags
  logic                res_found_r, res_found_nxt;
  logic                res_full_r, res_full_nxt;

  // registered memory reads
  logic [KEY_BITS-1:0] key_rd_r;
  logic [DATA_W-1:0]   addr_rd_r, stk_rd_r, ret_rd_r;

  out_word_t           out_data_r, out_data_nxt;

  // key of the incoming word: low KEY_BITS bits, zero-extended if wider
  logic [KEY_BITS+TASK_KEY_W-1:0] key_wide;
  logic [KEY_BITS-1:0]            key_in;
  assign key_wide = {{KEY_BITS{1'b0}}, in_data.task_key};
  assign key_in   = key_wide[KEY_BITS-1:0];

  logic in_fire;
  logic out_free;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // shared compare unit: one slot per cycle
  logic [KEY_BITS-1:0] eff_key;
  logic key_eq, slot_free, scan_hit, scan_last, scan_end;
  logic mem_we, data_re;

  always_comb begin
    eff_key   = valid_r[cmp_idx_r] ? key_rd_r : '0;
    key_eq    = (eff_key == key_r);
    slot_free = (eff_key == '0);
    case (op_r)
      OP_STAGE:  scan_hit = cmp_vld_r && (slot_free || key_eq);
      OP_TAKE:   scan_hit = cmp_vld_r && key_eq;
      OP_RESUME: scan_hit = cmp_vld_r && key_eq;
      default:   scan_hit = 1'b0;   // drop walks every slot
    endcase
    scan_last = cmp_vld_r && (cmp_idx_r == LAST_IDX);
    scan_end  = scan_hit || scan_last;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          st_nxt = (key_in == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          st_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_ready      = (st_r == ST_IDLE);
    valid_nxt     = valid_r;
    issue_idx_nxt = issue_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    data_re       = 1'b0;
    case (st_r)
      ST_IDLE: begin
        issue_idx_nxt = '0;
        cmp_vld_nxt   = 1'b0;
        res_found_nxt = 1'b0;
        res_full_nxt  = 1'b0;
      end
      ST_SCAN: begin
        cmp_idx_nxt   = issue_idx_r;
        cmp_vld_nxt   = 1'b1;
        issue_idx_nxt = (issue_idx_r == LAST_IDX) ? issue_idx_r : issue_idx_r + 1'b1;
        if (cmp_vld_r && op_r == OP_DROP && key_eq) begin
          valid_nxt[cmp_idx_r] = 1'b0;
        end
        if (scan_hit) begin
          case (op_r)
            OP_STAGE: begin
              mem_we               = 1'b1;
              valid_nxt[cmp_idx_r] = 1'b1;
            end
            OP_TAKE: begin
              data_re              = 1'b1;
              valid_nxt[cmp_idx_r] = 1'b0;
              res_found_nxt        = 1'b1;
            end
            OP_RESUME: begin
              data_re       = 1'b1;
              res_found_nxt = 1'b1;
            end
            default: ;
          endcase
        end else if (scan_last) begin
          res_full_nxt = (op_r == OP_STAGE);
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.found      = res_found_r;
          out_data_nxt.table_full = res_full_r;
          out_data_nxt.out_return =
            (res_found_r && op_r == OP_TAKE) ? ret_rd_r : '0;
          out_data_nxt.out_address =
            (res_found_r && op_r == OP_RESUME) ? addr_rd_r : '0;
          out_data_nxt.out_stack =
            (res_found_r && op_r == OP_RESUME) ? stk_rd_r : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      issue_idx_r <= '0;
      cmp_idx_r   <= '0;
      res_found_r <= 1'b0;
      res_full_r  <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      issue_idx_r <= issue_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      res_found_r <= res_found_nxt;
      res_full_r  <= res_full_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      op_r   <= in_data.kind;
      key_r  <= key_in;
      addr_r <= in_data.resume_address;
      stk_r  <= in_data.stack_value;
      ret_r  <= in_data.return_value;
    end
  end

  // key memory: one read port walked by the scan, write on stage hit
  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[issue_idx_r];
    if (mem_we) begin
      key_mem[cmp_idx_r] <= key_r;
    end
  end

  // record memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      addr_mem[cmp_idx_r] <= addr_r;
      stk_mem[cmp_idx_r]  <= stk_r;
      ret_mem[cmp_idx_r]  <= ret_r;
    end
    if (data_re) begin
      addr_rd_r <= addr_mem[cmp_idx_r];
      stk_rd_r  <= stk_mem[cmp_idx_r];
      ret_rd_r  <= ret_mem[cmp_idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a stage hit leaves its slot occupied
  a_stage_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN && scan_hit && op_r == OP_STAGE) |=> valid_r[$past(cmp_idx_r)])
    else $error("stage hit did not mark slot occupied");

  // a take hit frees its slot
  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN && scan_hit && op_r == OP_TAKE) |=> !valid_r[$past(cmp_idx_r)])
    else $error("take hit did not free slot");

  // full is reported only with every slot occupied
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RESULT && res_full_r) |-> (&valid_r))
    else $error("table_full with a free slot");

  // found and full never come together
  a_found_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.found && out_data_r.table_full))
    else $error("found and table_full both set");

  // a result is loaded only when the register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

FILE: tb/sv/krst_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// krst_checker: result predictor and scoreboard for the slot table
// Mirrors the slot table from accepted input words and compares each
// accepted result word against the oldest predicted word.
// ----------------------------------------------------------------------------
module krst_checker #(
  parameter int SLOT_COUNT = 16,
  parameter int KEY_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  krst_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  krst_pkg::out_word_t out_data,
  output int                  mismatch_count,
  output int                  pending_results
);
  import krst_pkg::*;

  localparam logic [31:0] KEY_MASK =
    (KEY_BITS >= 32) ? 32'hFFFF_FFFF : (32'd1 << KEY_BITS) - 32'd1;

  // shadow copy of the table
  logic [TASK_KEY_W-1:0] shadow_key   [SLOT_COUNT];
  logic [DATA_W-1:0]     shadow_addr  [SLOT_COUNT];
  logic [DATA_W-1:0]     shadow_stack [SLOT_COUNT];
  logic [DATA_W-1:0]     shadow_ret   [SLOT_COUNT];

  out_word_t predicted_words_q[$];
  out_word_t oldest_word;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // first slot holding the key, -1 if none
  function automatic int first_slot_with(input logic [TASK_KEY_W-1:0] key);
    int hit;
    hit = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (shadow_key[i] == key) hit = i;
    end
    return hit;
  endfunction

  function automatic out_word_t apply_table_op(input in_word_t w);
    out_word_t             res;
    logic [TASK_KEY_W-1:0] key;
    int                    hit;
    res = '0;
    key = w.task_key & KEY_MASK[TASK_KEY_W-1:0];
    if (key == '0) return res;
    case (w.kind)
      OP_STAGE: begin
        hit = -1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (hit < 0 && (shadow_key[i] == '0 || shadow_key[i] == key)) hit = i;
        end
        if (hit < 0) begin
          res.table_full = 1'b1;
        end else begin
          shadow_key[hit]   = key;
          shadow_addr[hit]  = w.resume_address;
          shadow_stack[hit] = w.stack_value;
          shadow_ret[hit]   = w.return_value;
        end
      end
      OP_DROP: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (shadow_key[i] == key) shadow_key[i] = '0;
        end
      end
      OP_TAKE: begin
        hit = first_slot_with(key);
        if (hit >= 0) begin
          shadow_key[hit] = '0;
          res.found       = 1'b1;
          res.out_return  = shadow_ret[hit];
        end
      end
      default: begin
        hit = first_slot_with(key);
        if (hit >= 0) begin
          res.found       = 1'b1;
          res.out_address = shadow_addr[hit];
          res.out_stack   = shadow_stack[hit];
        end
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input out_word_t exp_w,
                               input out_word_t act_w);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t krst_checker: %s exp found=%b full=%b ret=%h addr=%h stk=%h",
               $realtime, what, exp_w.found, exp_w.table_full, exp_w.out_return,
               exp_w.out_address, exp_w.out_stack);
    if (mismatch_count <= 10)
      $display("%0t krst_checker: %s act found=%b full=%b ret=%h addr=%h stk=%h",
               $realtime, what, act_w.found, act_w.table_full, act_w.out_return,
               act_w.out_address, act_w.out_stack);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) shadow_key[i] = '0;
      predicted_words_q.delete();
    end else begin
      // result side first: the word leaving belongs to an earlier input
      if (out_valid && out_ready) begin
        if (predicted_words_q.size() == 0) begin
          note_mismatch("unexpected word", '0, out_data);
        end else begin
          oldest_word = predicted_words_q.pop_front();
          if (out_data.found       !== oldest_word.found       ||
              out_data.table_full  !== oldest_word.table_full  ||
              out_data.out_return  !== oldest_word.out_return  ||
              out_data.out_address !== oldest_word.out_address ||
              out_data.out_stack   !== oldest_word.out_stack)
            note_mismatch("field mismatch", oldest_word, out_data);
        end
      end
      if (in_valid && in_ready)
        predicted_words_q.push_back(apply_table_op(in_data));
    end
    pending_results = predicted_words_q.size();
  end

endmodule

FILE: tb/sv/tb_keyed_resume_slot_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_resume_slot_table: stimulus and verdict for the slot table
// Directed words (zero keys, full table, overwrite, no-match cases), then
// random words over a small key pool with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_keyed_resume_slot_table;
  import krst_pkg::*;

  localparam int SLOT_COUNT  = 16;
  localparam int KEY_BITS    = 16;
  localparam int BLOCKS      = 11;   // random part, in blocks of words
  localparam int BLOCK_WORDS = 50;
  localparam int POOL_SIZE   = 20;   // more keys than slots, so the table fills
  localparam int DRAIN_WAIT  = 40;   // idle wait after the final drain
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;

  // when set, that side runs without gaps
  logic sender_calm   = 1'b0;
  logic receiver_calm = 1'b0;
  logic reset_done    = 1'b0;

  logic [TASK_KEY_W-1:0] key_pool [POOL_SIZE];

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keyed_resume_slot_table #(
    .SLOT_COUNT(SLOT_COUNT),
    .KEY_BITS  (KEY_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  krst_checker #(
    .SLOT_COUNT(SLOT_COUNT),
    .KEY_BITS  (KEY_BITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_keyed_resume_slot_table: done, errors");
      $finish;
    end
  end

  // result side: per word, a random stall before ready
  initial begin : result_stall
    int stall;
    out_ready = 1'b0;
    wait (reset_done);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 6);
      repeat (stall) @(negedge clk) out_ready <= 1'b0;
      @(negedge clk) out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  function automatic in_word_t mk_word(input op_t kind, input logic [15:0] key,
                                       input logic [31:0] addr,
                                       input logic [31:0] stk,
                                       input logic [31:0] ret);
    in_word_t w;
    w.kind           = kind;
    w.task_key       = key;
    w.resume_address = addr;
    w.stack_value    = stk;
    w.return_value   = ret;
    return w;
  endfunction

  // mostly random data, sometimes the extremes
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // weighted ops; keys mostly from the pool so hits, fills and drops happen
  function automatic in_word_t random_word();
    op_t                   kind;
    logic [TASK_KEY_W-1:0] key;
    int                    r;
    r = $urandom_range(0, 99);
    if (r < 35)      kind = OP_STAGE;
    else if (r < 50) kind = OP_DROP;
    else if (r < 75) kind = OP_TAKE;
    else             kind = OP_RESUME;
    r = $urandom_range(0, 99);
    if (r < 5)       key = '0;
    else if (r < 15) key = TASK_KEY_W'($urandom);
    else             key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return mk_word(kind, key, pick_value(), pick_value(), pick_value());
  endfunction

  // one word: gap cycles of idle, then hold valid until accepted
  task automatic send_word(input in_word_t w);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender holds off until every predicted word has come back
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    op_t op;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    reset_done = 1'b1;

    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0001;
    key_pool[2] = 16'h8000;
    for (int i = 3; i < POOL_SIZE; i++)
      key_pool[i] = TASK_KEY_W'($urandom_range(1, 16'hFFFF));

    // zero key: every op must come back all zero
    op = OP_STAGE;
    for (int i = 0; i < 4; i++) begin
      send_word(mk_word(op, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      op = op.next();
    end

    // fill the table: all-ones key/data first, then one key per key bit 0..14
    send_word(mk_word(OP_STAGE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF));
    send_word(mk_word(OP_STAGE, 16'h0001, 32'h0, 32'h0, 32'h0));
    for (int i = 1; i < 15; i++)
      send_word(mk_word(OP_STAGE, 16'h0001 << i, $urandom, $urandom, $urandom));

    // full table: new key is refused, a held key still overwrites
    send_word(mk_word(OP_STAGE, 16'h8000, $urandom, $urandom, $urandom));
    send_word(mk_word(OP_STAGE, 16'h0001, $urandom, $urandom, $urandom));

    send_word(mk_word(OP_RESUME, 16'hFFFF, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(OP_TAKE, 16'hFFFF, 32'h0, 32'h0, 32'h0));
    // no match after take freed it
    send_word(mk_word(OP_TAKE, 16'hFFFF, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(OP_DROP, 16'h0001, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(OP_RESUME, 16'h0001, 32'h0, 32'h0, 32'h0));

    // random part; idle modes change per block, block 1 always runs flat out
    for (int b = 0; b < BLOCKS; b++) begin
      @(negedge clk);
      sender_calm   <= (b == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
      receiver_calm <= (b == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCK_WORDS; n++)
        send_word(random_word());
      if (b == 3 || $urandom_range(0, 2) == 0)
        drain_results();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_keyed_resume_slot_table: done, clean");
    end else begin
      $display("tb_keyed_resume_slot_table: done, errors");
    end
    $finish;
  end

endmodule
